FILE: rtl/core/sps_pkg.sv
// Package for the sensor poll sequencer: payload structs, action and error codes,
// configuration register indexes and reset values. Used by every other file.
package sps_pkg;

  localparam int unsigned CountW  = 8;
  localparam int unsigned TempW   = 12;
  localparam int unsigned LimitW  = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 16;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_STARTUP_LIMIT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_POLL_LIMIT    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_PAUSE_LIMIT   = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_IGNORE_CRC    = 2'd3;

  // Reset values of the configuration registers
  localparam logic [LimitW-1:0] STARTUP_LIMIT_RST = 16'd10;
  localparam logic [LimitW-1:0] POLL_LIMIT_RST    = 16'd100;
  localparam logic [LimitW-1:0] PAUSE_LIMIT_RST   = 16'd10;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_LOW  = 2'd1,
    ACT_INIT = 2'd2,
    ACT_READ = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_NOSENSOR = 2'd1,
    ERR_CRC      = 2'd2
  } error_e;

  typedef struct packed {
    logic [CountW-1:0]       sensor_count;
    logic signed [TempW-1:0] sensor_temp;
    logic                    crc_ok;
  } tick_t;

  typedef struct packed {
    action_e                 action;
    error_e                  error_code;
    logic signed [TempW-1:0] temperature;
  } result_t;

  typedef struct packed {
    logic [LimitW-1:0] startup_limit;
    logic [LimitW-1:0] poll_limit;
    logic [LimitW-1:0] pause_limit;
    logic              ignore_crc;
  } cfg_t;

endpackage

FILE: rtl/core/sps_if.sv
// Valid/ready channel interfaces for the tick input and the result output.
// The count and temperature widths come from sps_pkg.
interface sps_tick_if;
  logic                                 valid;
  logic                                 ready;
  logic [sps_pkg::CountW-1:0]           sensor_count;
  logic signed [sps_pkg::TempW-1:0]     sensor_temp;
  logic                                 crc_ok;

  modport source (output valid, output sensor_count, output sensor_temp, output crc_ok,
                  input ready);
  modport sink (input valid, input sensor_count, input sensor_temp, input crc_ok,
                output ready);
endinterface

interface sps_result_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       action;
  logic [1:0]                       error_code;
  logic signed [sps_pkg::TempW-1:0] temperature;

  modport source (output valid, output action, output error_code, output temperature,
                  input ready);
  modport sink (input valid, input action, input error_code, input temperature,
                output ready);
endinterface

FILE: rtl/core/sps_tick.sv
// Sequencer state and per-tick decision logic: poll timer, recovery pause,
// reinit flag, error code and last temperature. Depends on sps_pkg.
module sps_tick (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  sps_pkg::tick_t   tick_i,
  input  sps_pkg::cfg_t    cfg_i,
  output sps_pkg::result_t res_o
);

  logic                             timer_disabled_q, timer_disabled_d;
  logic [sps_pkg::LimitW-1:0]       startup_count_q, startup_count_d;
  logic [sps_pkg::LimitW-1:0]       poll_count_q, poll_count_d;
  logic                             startup_done_q, startup_done_d;
  logic                             line_low_pending_q, line_low_pending_d;
  logic [sps_pkg::LimitW-1:0]       pause_count_q, pause_count_d;
  logic                             need_init_q, need_init_d;
  sps_pkg::error_e                  error_state_q, error_state_d;
  logic signed [sps_pkg::TempW-1:0] last_temp_q, last_temp_d;

  logic             due;
  sps_pkg::action_e act;

  // Next state and action for the tick that is being retired.
  always_comb begin
    timer_disabled_d   = timer_disabled_q;
    startup_count_d    = startup_count_q;
    poll_count_d       = poll_count_q;
    startup_done_d     = startup_done_q;
    line_low_pending_d = line_low_pending_q;
    pause_count_d      = pause_count_q;
    need_init_d        = need_init_q;
    error_state_d      = error_state_q;
    last_temp_d        = last_temp_q;
    due                = 1'b0;
    act                = sps_pkg::ACT_NONE;

    // Poll timer: disabled mode and startup phase make every tick due.
    if (timer_disabled_q) begin
      startup_count_d = '0;
      poll_count_d    = '0;
      due             = 1'b1;
    end else if (!startup_done_q && (startup_count_q <= cfg_i.startup_limit)) begin
      startup_count_d = startup_count_q + 1'b1;
      due             = 1'b1;
    end else begin
      // The tick that ends startup is judged by the normal poll counter.
      if (!startup_done_q) begin
        startup_count_d = '0;
        startup_done_d  = 1'b1;
      end
      if (poll_count_q <= cfg_i.poll_limit) begin
        poll_count_d = poll_count_q + 1'b1;
      end else begin
        poll_count_d = '0;
        due          = 1'b1;
      end
    end

    if (due) begin
      if (line_low_pending_q && (pause_count_q < cfg_i.pause_limit)) begin
        pause_count_d = pause_count_q + 1'b1;
        act           = sps_pkg::ACT_LOW;
      end else begin
        if (line_low_pending_q) begin
          pause_count_d      = '0;
          line_low_pending_d = 1'b0;
        end
        if (need_init_q) begin
          need_init_d = 1'b0;
          act         = sps_pkg::ACT_INIT;
        end else begin
          act = sps_pkg::ACT_READ;
          if (tick_i.sensor_count == '0) begin
            error_state_d      = sps_pkg::ERR_NOSENSOR;
            line_low_pending_d = 1'b1;
            timer_disabled_d   = 1'b1;
            need_init_d        = 1'b1;
          end else begin
            // A bad CRC still stores the temperature.
            last_temp_d      = tick_i.sensor_temp;
            error_state_d    = sps_pkg::ERR_NONE;
            timer_disabled_d = 1'b0;
            if (!tick_i.crc_ok && !cfg_i.ignore_crc) begin
              error_state_d      = sps_pkg::ERR_CRC;
              line_low_pending_d = 1'b1;
              timer_disabled_d   = 1'b1;
              need_init_d        = 1'b1;
            end
          end
        end
      end
    end

    res_o.action      = act;
    res_o.error_code  = error_state_d;
    res_o.temperature = last_temp_d;
  end

  // State registers advance once per retired tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_disabled_q   <= 1'b0;
      startup_count_q    <= '0;
      poll_count_q       <= '0;
      startup_done_q     <= 1'b0;
      line_low_pending_q <= 1'b0;
      pause_count_q      <= '0;
      need_init_q        <= 1'b0;
      error_state_q      <= sps_pkg::ERR_NONE;
      last_temp_q        <= '0;
    end else if (en_i) begin
      timer_disabled_q   <= timer_disabled_d;
      startup_count_q    <= startup_count_d;
      poll_count_q       <= poll_count_d;
      startup_done_q     <= startup_done_d;
      line_low_pending_q <= line_low_pending_d;
      pause_count_q      <= pause_count_d;
      need_init_q        <= need_init_d;
      error_state_q      <= error_state_d;
      last_temp_q        <= last_temp_d;
    end
  end

`ifndef SYNTHESIS
  // A line-low tick leaves the recovery pause pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && (act == sps_pkg::ACT_LOW) |=> line_low_pending_q)
    else $error("line low issued without a pending pause");

  // An init tick consumes the reinit request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && (act == sps_pkg::ACT_INIT) |=> !need_init_q)
    else $error("reinit request not cleared by init");

  // A tick with no action leaves the error code and temperature alone.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && (act == sps_pkg::ACT_NONE) |=> $stable(error_state_q) && $stable(last_temp_q))
    else $error("idle tick changed error or temperature");
`endif

endmodule

FILE: rtl/core/sensor_poll_sequencer_top.sv
// Top level of the sensor poll sequencer: configuration registers, input
// register, result register. Depends on sps_pkg, sps_if.sv and sps_tick.
//
// One tick beat in gives one result beat out. The block takes a beat every
// clock cycle when the output is not stalled; a beat enters an input
// register, its decision is made by sps_tick when it advances and lands in
// the result register, where it is held until it is taken. The input
// register and the result register together hold two beats, so a new tick
// is accepted while a finished result waits to be taken.
// Configuration registers are written with cfg_we_i, cfg_idx_i and cfg_data_i
// (0 startup_limit, 1 poll_limit, 2 pause_limit, 3 ignore_crc (bit 0)); the
// user must write them only while no tick is in flight, as the block itself
// does not enforce it.
module sensor_poll_sequencer_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sps_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [sps_pkg::CfgW-1:0]      cfg_data_i,
  sps_tick_if.sink                      in_i,
  sps_result_if.source                  out_o
);

  sps_pkg::cfg_t    cfg_q;
  logic             in_valid_q;
  sps_pkg::tick_t   in_data_q;
  logic             out_valid_q;
  sps_pkg::result_t out_data_q;
  sps_pkg::result_t res;
  logic             advance;
  logic             in_take;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.startup_limit <= sps_pkg::STARTUP_LIMIT_RST;
      cfg_q.poll_limit    <= sps_pkg::POLL_LIMIT_RST;
      cfg_q.pause_limit   <= sps_pkg::PAUSE_LIMIT_RST;
      cfg_q.ignore_crc    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sps_pkg::CFG_STARTUP_LIMIT: cfg_q.startup_limit <= cfg_data_i;
        sps_pkg::CFG_POLL_LIMIT:    cfg_q.poll_limit    <= cfg_data_i;
        sps_pkg::CFG_PAUSE_LIMIT:   cfg_q.pause_limit   <= cfg_data_i;
        sps_pkg::CFG_IGNORE_CRC:    cfg_q.ignore_crc    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Handshake: the held tick retires when the result register is free or drains.
  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;
  assign in_take    = in_i.valid && in_i.ready;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_data_q.sensor_count <= in_i.sensor_count;
      in_data_q.sensor_temp  <= in_i.sensor_temp;
      in_data_q.crc_ok       <= in_i.crc_ok;
    end
  end

  sps_tick u_tick (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .tick_i (in_data_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= res;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.action      = out_data_q.action;
  assign out_o.error_code  = out_data_q.error_code;
  assign out_o.temperature = out_data_q.temperature;

`ifndef SYNTHESIS
  // A retired tick always shows up in the result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("retired tick produced no result beat");

  // An accepted beat is held in the input register next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> in_valid_q)
    else $error("accepted tick beat was dropped");

  // Without a retiring tick, the result register never gains a new beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance && !out_valid_q |=> !out_valid_q)
    else $error("result beat appeared without a tick");
`endif

endmodule

FILE: verif/tb.sv
// Testbench for sensor_poll_sequencer_top: a bursty tick sender, a stalling result
// receiver and a scoreboard that predicts every result beat from its own model of the
// poll timer and recovery logic. Depends on sps_pkg, sps_if.sv and the top level.
module tb;
  import sps_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned PhaseCount  = 12;
  localparam int unsigned PhaseTicks  = 70;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned HoldCycles  = 60;
  localparam int unsigned HoldAfter   = 300;

  // Scoreboard: keeps a copy of the sequencer state and the expected result beats.
  class poll_scoreboard;
    logic [LimitW-1:0]       startup_limit;
    logic [LimitW-1:0]       poll_limit;
    logic [LimitW-1:0]       pause_limit;
    logic                    ignore_crc;
    logic                    timer_off;
    logic                    startup_done;
    logic                    low_pending;
    logic                    init_pending;
    logic [LimitW-1:0]       startup_cnt;
    logic [LimitW-1:0]       poll_cnt;
    logic [LimitW-1:0]       pause_cnt;
    error_e                  err;
    logic signed [TempW-1:0] temp;
    result_t                 expected_results[$];
    int unsigned             fails;

    function new();
      startup_limit = STARTUP_LIMIT_RST;
      poll_limit    = POLL_LIMIT_RST;
      pause_limit   = PAUSE_LIMIT_RST;
      ignore_crc    = 1'b0;
      timer_off     = 1'b0;
      startup_done  = 1'b0;
      low_pending   = 1'b0;
      init_pending  = 1'b0;
      startup_cnt   = '0;
      poll_cnt      = '0;
      pause_cnt     = '0;
      err           = ERR_NONE;
      temp          = '0;
      fails         = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
      case (idx)
        CFG_STARTUP_LIMIT: startup_limit = data;
        CFG_POLL_LIMIT:    poll_limit    = data;
        CFG_PAUSE_LIMIT:   pause_limit   = data;
        CFG_IGNORE_CRC:    ignore_crc    = data[0];
        default: ;
      endcase
    endfunction

    // Poll timer: startup ticks and disabled mode are always due; the normal
    // phase is due once the counter has passed the limit.
    function logic poll_due();
      if (timer_off) begin
        startup_cnt = '0;
        poll_cnt    = '0;
        return 1'b1;
      end
      if (!startup_done) begin
        if (startup_cnt <= startup_limit) begin
          startup_cnt = startup_cnt + 16'd1;
          return 1'b1;
        end
        startup_cnt  = '0;
        startup_done = 1'b1;
      end
      if (poll_cnt <= poll_limit) begin
        poll_cnt = poll_cnt + 16'd1;
        return 1'b0;
      end
      poll_cnt = '0;
      return 1'b1;
    endfunction

    function void start_recovery();
      low_pending  = 1'b1;
      timer_off    = 1'b1;
      init_pending = 1'b1;
    endfunction

    // Action of one tick: line-low pause first, then init, then a read.
    function action_e tick_action(tick_t t);
      if (!poll_due()) return ACT_NONE;
      if (low_pending) begin
        if (pause_cnt < pause_limit) begin
          pause_cnt = pause_cnt + 16'd1;
          return ACT_LOW;
        end
        pause_cnt   = '0;
        low_pending = 1'b0;
      end
      if (init_pending) begin
        init_pending = 1'b0;
        return ACT_INIT;
      end
      if (t.sensor_count == '0) begin
        err = ERR_NOSENSOR;
        start_recovery();
        return ACT_READ;
      end
      timer_off = 1'b0;
      err       = ERR_NONE;
      temp      = t.sensor_temp;
      // A bad CRC still updates the stored temperature.
      if (!t.crc_ok && !ignore_crc) begin
        err = ERR_CRC;
        start_recovery();
      end
      return ACT_READ;
    endfunction

    function void note_tick(tick_t t);
      result_t r;
      r.action      = tick_action(t);
      r.error_code  = err;
      r.temperature = temp;
      expected_results.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (expected_results.size() == 0) begin
        $error("unexpected result beat: action %0d", got.action);
        fails++;
        return;
      end
      exp = expected_results.pop_front();
      if (got.action !== exp.action) begin
        $error("action: expected %0d, got %0d", exp.action, got.action);
        fails++;
      end
      if (got.error_code !== exp.error_code) begin
        $error("error_code: expected %0d, got %0d", exp.error_code, got.error_code);
        fails++;
      end
      if (got.temperature !== exp.temperature) begin
        $error("temperature: expected %0d, got %0d", exp.temperature, got.temperature);
        fails++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgW-1:0]     cfg_data;
  poll_scoreboard      sb;
  int unsigned         cycles;
  int unsigned         results_seen;
  int unsigned         burst_left;
  logic                gaps_on;

  sps_tick_if   tick_if ();
  sps_result_if result_if ();

  sensor_poll_sequencer_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (tick_if),
    .out_o      (result_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Result monitor: every accepted result beat goes to the scoreboard.
  initial begin
    result_t got;
    results_seen = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && result_if.valid && result_if.ready) begin
        got.action      = action_e'(result_if.action);
        got.error_code  = error_e'(result_if.error_code);
        got.temperature = result_if.temperature;
        sb.check_result(got);
        results_seen++;
      end
    end
  end

  // Receiver: free-flowing stretches, random stalls, and one long hold-off
  // that lets the block fill up and stall its input.
  initial begin
    int unsigned run_len;
    int unsigned mode;
    logic        held;
    held = 1'b0;
    result_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (!held && results_seen >= HoldAfter) begin
        result_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        held = 1'b1;
      end
      mode    = $urandom_range(0, 2);
      run_len = $urandom_range(5, 40);
      repeat (run_len) begin
        result_if.ready <= (mode == 0) ? 1'b1 : ($urandom_range(0, 99) >= 35);
        @(posedge clk_i);
      end
    end
  end

  // Offer one tick beat and wait until it is taken; the sender works in bursts.
  task automatic send_tick(tick_t t);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
        tick_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    tick_if.valid        <= 1'b1;
    tick_if.sensor_count <= t.sensor_count;
    tick_if.sensor_temp  <= t.sensor_temp;
    tick_if.crc_ok       <= t.crc_ok;
    do @(posedge clk_i); while (!tick_if.ready);
    sb.note_tick(t);
  endtask

  task automatic send(logic [CountW-1:0] count, logic [TempW-1:0] temp_in, logic ok);
    tick_t t;
    t.sensor_count = count;
    t.sensor_temp  = temp_in;
    t.crc_ok       = ok;
    send_tick(t);
  endtask

  // Stop sending until every expected result has come, then let the block settle.
  task automatic drain();
    tick_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    burst_left = 0;
  endtask

  // Write all four registers; only called while the block is idle.
  task automatic set_config(logic [LimitW-1:0] su, logic [LimitW-1:0] pl,
                            logic [LimitW-1:0] pa, logic ic);
    logic [CfgIdxW-1:0] idx [4];
    logic [CfgW-1:0]    val [4];
    idx[0] = CFG_STARTUP_LIMIT; val[0] = su;
    idx[1] = CFG_POLL_LIMIT;    val[1] = pl;
    idx[2] = CFG_PAUSE_LIMIT;   val[2] = pa;
    idx[3] = CFG_IGNORE_CRC;    val[3] = {{(CfgW-1){1'b0}}, ic};
    for (int i = 0; i < 4; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= idx[i];
      cfg_data <= val[i];
      @(posedge clk_i);
      sb.write_reg(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // Main sequence: directed ticks, then random phases with changing settings.
  initial begin
    tick_t             t;
    int unsigned       r;
    logic [LimitW-1:0] su;
    logic [LimitW-1:0] pl;
    logic [LimitW-1:0] pa;
    logic              ic;
    sb = new();
    tick_if.valid        = 1'b0;
    tick_if.sensor_count = '0;
    tick_if.sensor_temp  = '0;
    tick_if.crc_ok       = 1'b0;
    cfg_we     = 1'b0;
    cfg_idx    = CFG_STARTUP_LIMIT;
    cfg_data   = '0;
    burst_left = 0;
    gaps_on    = 1'b1;
    rst_ni     = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: startup ticks read straight away.
    send(8'd2, 12'h010, 1'b1);
    send(8'd1, 12'h020, 1'b1);
    send(8'd3, 12'hff0, 1'b1);
    drain();

    // Startup that never ends: every tick is due.
    set_config(16'hffff, 16'd0, 16'd1, 1'b0);
    send(8'd1, 12'h7ff, 1'b1);
    send(8'd255, 12'h800, 1'b1);
    send(8'd0, 12'h123, 1'b1);   // no sensor starts a recovery
    send(8'd0, 12'h000, 1'b0);   // line low
    send(8'd0, 12'hfff, 1'b0);   // init, inputs ignored
    send(8'h80, 12'h555, 1'b0);  // bad CRC still stores the temperature
    send(8'd7, 12'h001, 1'b1);
    send(8'd9, 12'h002, 1'b1);
    send(8'd1, 12'hfff, 1'b1);
    drain();

    // Leaving startup with CRC errors ignored and no line-low pause.
    set_config(16'd0, 16'd0, 16'd0, 1'b1);
    send(8'd5, 12'h064, 1'b0);
    send(8'd5, 12'h2aa, 1'b0);
    send(8'd6, 12'h3ff, 1'b1);
    send(8'd0, 12'h444, 1'b1);
    send(8'd0, 12'h111, 1'b1);
    send(8'd3, 12'h000, 1'b0);
    send(8'd4, 12'h7f0, 1'b0);
    send(8'd4, 12'h80f, 1'b1);
    drain();

    for (int p = 0; p < PhaseCount; p++) begin
      case (p)
        0: begin
          su = 16'd0; pl = 16'd0; pa = 16'd0; ic = 1'b0;
        end
        1: begin
          su = 16'hffff; pl = 16'hffff; pa = 16'hffff; ic = 1'b1;
        end
        default: begin
          su = LimitW'($urandom_range(0, 8));
          pl = ($urandom_range(0, 5) == 0) ? LimitW'($urandom_range(0, 65535))
                                           : LimitW'($urandom_range(0, 6));
          pa = ($urandom_range(0, 7) == 0) ? LimitW'($urandom_range(0, 65535))
                                           : LimitW'($urandom_range(0, 4));
          ic = 1'($urandom_range(0, 1));
        end
      endcase
      set_config(su, pl, pa, ic);
      gaps_on = (p % 4 != 2);
      repeat (PhaseTicks) begin
        r = $urandom_range(0, 99);
        t.sensor_temp  = TempW'($urandom());
        t.sensor_count = ($urandom_range(0, 7) == 0) ? 8'd255
                                                     : CountW'($urandom_range(1, 255));
        t.crc_ok       = 1'b1;
        // Mostly healthy replies; some missing sensors and CRC failures.
        if (r < 10) begin
          t.sensor_count = '0;
          t.crc_ok       = 1'($urandom_range(0, 1));
        end else if (r < 22) begin
          t.crc_ok = 1'b0;
        end
        send_tick(t);
      end
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (sb.fails == 0 && sb.expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
